>>> rtl/core/jfns_pkg.sv
// Shared constants, types and helper functions for the Jacobi five-point stencil.
// Used by the interfaces, jfns_scan, jfns_avg and the top; depends on nothing.
package jfns_pkg;

	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF = 32;

	localparam int GW_BITS       = 11;
	localparam int GH_BITS       = 16;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 3;

	// register index, taken from paddr[2]
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	localparam logic [GW_BITS-1:0] GRID_WIDTH_RST  = 11'd1024;
	localparam logic [GH_BITS-1:0] GRID_HEIGHT_RST = 16'd1024;

	// per-sample flags handed from the scan counters to the averaging stage
	typedef struct packed {
		logic has_result;
		logic frame_last;
	} jfns_tag_t;

	// clamp the programmed width to 3..max_w
	function automatic int eff_width(logic [GW_BITS-1:0] gw, int max_w);
		int w;
		w = int'(gw);
		if (w < 3)
			w = 3;
		if (w > max_w)
			w = max_w;
		return w;
	endfunction

	// heights below three act as three
	function automatic logic [GH_BITS-1:0] eff_height(logic [GH_BITS-1:0] gh);
		return (gh < GH_BITS'(3)) ? GH_BITS'(3) : gh;
	endfunction

endpackage

>>> rtl/core/jfns_if.sv
// Valid/ready stream interfaces for grid samples in and stencil results out.
// Depends on jfns_pkg for the default sample width.
interface jfns_in_if #(
	parameter int SAMPLE_BITS = jfns_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface jfns_out_if #(
	parameter int SAMPLE_BITS = jfns_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] new_value;
	logic                          frame_last;

	modport source (output valid, output new_value, output frame_last, input ready);
	modport sink   (input valid, input new_value, input frame_last, output ready);
endinterface

>>> rtl/core/jfns_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies; contents are not reset.
module jfns_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/jfns_scan.sv
// Configuration registers and raster scan counters; produces line-buffer addresses
// and per-sample flags. Depends on jfns_pkg.
module jfns_scan #(
	parameter int MAX_WIDTH = jfns_pkg::MAX_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr,
	input  logic                                 cfg_sel,
	input  logic [jfns_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                 accept,
	output logic [jfns_pkg::GW_BITS-1:0]         grid_width,
	output logic [jfns_pkg::GH_BITS-1:0]         grid_height,
	output logic [$clog2(MAX_WIDTH)-1:0]         col,
	output logic [$clog2(MAX_WIDTH)-1:0]         upper_raddr,
	output logic [$clog2(MAX_WIDTH)-1:0]         middle_raddr,
	output jfns_pkg::jfns_tag_t                  tag
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int GW = jfns_pkg::GW_BITS;
	localparam int GH = jfns_pkg::GH_BITS;

	logic [GW-1:0] grid_width_q;
	logic [GH-1:0] grid_height_q;
	logic [GW-1:0] gw_nxt;
	logic [GH-1:0] gh_nxt;
	logic [CW-1:0] w_m1_q;
	logic [CW-1:0] w_m2_q;
	logic [GH-1:0] h_m1_q;
	logic [CW-1:0] col_q;
	logic [GH-1:0] row_q;
	logic          col_last;

	always_comb begin
		gw_nxt = grid_width_q;
		gh_nxt = grid_height_q;
		unique case (cfg_sel)
			jfns_pkg::REG_GRID_WIDTH:  gw_nxt = cfg_data[GW-1:0];
			jfns_pkg::REG_GRID_HEIGHT: gh_nxt = cfg_data[GH-1:0];
			default: ;
		endcase
	end

	assign col_last = (col_q == w_m1_q);

	// prefetch one column ahead for the row above, two ahead for the middle row
	assign upper_raddr  = col_last ? '0 : CW'(col_q + CW'(1));
	assign middle_raddr = (col_q == w_m2_q) ? '0 :
	                      col_last          ? CW'(1) : CW'(col_q + CW'(2));

	assign tag.has_result = (row_q >= GH'(2)) && (col_q != '0) && (col_q <= w_m2_q);
	assign tag.frame_last = (row_q == h_m1_q) && (col_q == w_m2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= jfns_pkg::GRID_WIDTH_RST;
			grid_height_q <= jfns_pkg::GRID_HEIGHT_RST;
			w_m1_q <= CW'(jfns_pkg::eff_width(jfns_pkg::GRID_WIDTH_RST, MAX_WIDTH) - 1);
			w_m2_q <= CW'(jfns_pkg::eff_width(jfns_pkg::GRID_WIDTH_RST, MAX_WIDTH) - 2);
			h_m1_q <= jfns_pkg::eff_height(jfns_pkg::GRID_HEIGHT_RST) - GH'(1);
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_wr) begin
			// any register write restarts the frame
			grid_width_q  <= gw_nxt;
			grid_height_q <= gh_nxt;
			w_m1_q <= CW'(jfns_pkg::eff_width(gw_nxt, MAX_WIDTH) - 1);
			w_m2_q <= CW'(jfns_pkg::eff_width(gw_nxt, MAX_WIDTH) - 2);
			h_m1_q <= jfns_pkg::eff_height(gh_nxt) - GH'(1);
			col_q  <= '0;
			row_q  <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= (row_q == h_m1_q) ? '0 : GH'(row_q + GH'(1));
			end else begin
				col_q <= CW'(col_q + CW'(1));
			end
		end
	end

	assign grid_width  = grid_width_q;
	assign grid_height = grid_height_q;
	assign col         = col_q;

endmodule

>>> rtl/core/jfns_avg.sv
// Operand stage and output register: sums the four neighbors and floors by four.
// Depends on jfns_pkg and jfns_out_if.
module jfns_avg #(
	parameter int SAMPLE_BITS = jfns_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  jfns_pkg::jfns_tag_t           tag,
	input  logic signed [SAMPLE_BITS-1:0] north,
	input  logic signed [SAMPLE_BITS-1:0] south,
	input  logic signed [SAMPLE_BITS-1:0] west,
	input  logic signed [SAMPLE_BITS-1:0] east,
	output logic                          ready,
	jfns_out_if.source                    results
);

	localparam int SW = SAMPLE_BITS + 2;

	logic                          valid_s1;
	logic                          last_s1;
	logic signed [SAMPLE_BITS-1:0] north_s1, south_s1, west_s1, east_s1;
	logic                          out_valid_q;
	logic                          out_last_q;
	logic signed [SAMPLE_BITS-1:0] out_value_q;
	logic                          out_free;
	logic signed [SW-1:0]          sum;

	assign out_free = !out_valid_q || results.ready;
	assign ready    = !valid_s1 || out_free;

	assign sum = SW'(north_s1) + SW'(south_s1) + SW'(west_s1) + SW'(east_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready)
				valid_s1 <= load && tag.has_result;
			if (out_free)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && ready) begin
			north_s1 <= north;
			south_s1 <= south;
			west_s1  <= west;
			east_s1  <= east;
			last_s1  <= tag.frame_last;
		end
		// drop the two low bits: arithmetic shift floors toward minus infinity
		if (out_free && valid_s1) begin
			out_value_q <= sum[SW-1:2];
			out_last_q  <= last_s1;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.new_value  = out_value_q;
	assign results.frame_last = out_last_q;

endmodule

>>> rtl/core/jacobi_four_neighbour_stencil.sv
// Jacobi five-point stencil over a raster-ordered grid stream, two line memories.
// Throughput: one sample per cycle; a held result stalls input once both stages are full.
// Beat (r,c) loads center (r-1,c) into the operand stage, then the output register.
// Reset: counters restart at row 0 column 0, grid_width and grid_height return to 1024,
// pipeline valids clear; line memories are not cleared and are refilled by the first rows.
// Depends on jfns_pkg, jfns_if, jfns_ram, jfns_scan and jfns_avg.
module jacobi_four_neighbour_stencil #(
	parameter int MAX_WIDTH   = jfns_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = jfns_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	jfns_in_if.sink                             samples,
	jfns_out_if.source                          results,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [jfns_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [jfns_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [jfns_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int DW = jfns_pkg::CFG_DATA_BITS;

	logic                                accept;
	logic                                cfg_wr;
	logic                                avg_ready;
	logic [jfns_pkg::GW_BITS-1:0]        grid_width;
	logic [jfns_pkg::GH_BITS-1:0]        grid_height;
	logic [CW-1:0]                       col;
	logic [CW-1:0]                       upper_raddr;
	logic [CW-1:0]                       middle_raddr;
	jfns_pkg::jfns_tag_t                 tag;
	logic [SAMPLE_BITS-1:0]              north;
	logic [SAMPLE_BITS-1:0]              east;
	// window over the middle row: prev_q holds column c, prev2_q column c-1
	logic [SAMPLE_BITS-1:0]              prev_q;
	logic [SAMPLE_BITS-1:0]              prev2_q;

	assign accept        = samples.valid && samples.ready;
	assign samples.ready = avg_ready;

	// APB: register written in the access phase; no wait states
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			jfns_pkg::REG_GRID_WIDTH:  prdata = DW'(grid_width);
			jfns_pkg::REG_GRID_HEIGHT: prdata = DW'(grid_height);
			default:                   prdata = '0;
		endcase
	end

	jfns_scan #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_wr),
		.cfg_sel      (paddr[2]),
		.cfg_data     (pwdata),
		.accept       (accept),
		.grid_width   (grid_width),
		.grid_height  (grid_height),
		.col          (col),
		.upper_raddr  (upper_raddr),
		.middle_raddr (middle_raddr),
		.tag          (tag)
	);

	// Row r-2. Write column c with the old middle value, prefetch column c+1 for
	// the next beat. Read and write addresses never meet since width is at least 3.
	jfns_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WIDTH)
	) u_upper_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (col),
		.wdata (prev_q),
		.re    (accept),
		.raddr (upper_raddr),
		.rdata (north)
	);

	// Row r-1. Write column c with the new sample, prefetch column c+2 so the east
	// neighbor of the next beat is ready; it then shifts into the window.
	jfns_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WIDTH)
	) u_middle_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (col),
		.wdata (samples.sample),
		.re    (accept),
		.raddr (middle_raddr),
		.rdata (east)
	);

	// Advance the window on every taken beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			prev2_q <= '0;
		end else if (accept) begin
			prev2_q <= prev_q;
			prev_q  <= east;
		end
	end

	jfns_avg #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_avg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.tag     (tag),
		.north   (north),
		.south   (samples.sample),
		.west    (prev2_q),
		.east    (east),
		.ready   (avg_ready),
		.results (results)
	);

endmodule
